### hdl/pwbf_pkg.sv
// Package for the pulse width button frame decoder.
// Holds widths, register indexes, button masks and the shared structs.
// No dependencies.
package pwbf_pkg;

    localparam int TIME_BITS      = 32;
    localparam int BITS_PER_FRAME = 8;
    localparam int COUNT_BITS     = $clog2(BITS_PER_FRAME);
    localparam int BUTTON_COUNT   = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_GAP   = 3'd0,
        REG_HIGH_THRESH = 3'd1,
        REG_IDLE        = 3'd2,
        REG_ON_MODE     = 3'd3,
        REG_IO_MODE     = 3'd4,
        REG_PLUS_MODE   = 3'd5,
        REG_MINUS_MODE  = 3'd6
    } cfg_reg_t;

    // Button order: 0 on, 1 io, 2 plus, 3 minus.
    localparam logic [BITS_PER_FRAME-1:0] BUTTON_MASK [BUTTON_COUNT] = '{
        8'h48, 8'h12, 8'h24, 8'h01
    };

    localparam logic [31:0] FRAME_GAP_RESET   = 32'd10000;
    localparam logic [31:0] HIGH_THRESH_RESET = 32'd1000;
    localparam logic [7:0]  IDLE_RESET        = 8'hFF;

    typedef struct packed {
        logic [31:0]             frame_gap_ticks;
        logic [31:0]             high_threshold_ticks;
        logic [7:0]              idle_pattern;
        logic [BUTTON_COUNT-1:0] toggle_mode;
    } cfg_t;

    typedef struct packed {
        logic [BITS_PER_FRAME-1:0] frame_byte;
        logic [BUTTON_COUNT-1:0]   buttons;
    } result_t;

endpackage

### hdl/pwbf_cfg.sv
// Configuration register file for the frame decoder.
// Depends on pwbf_pkg.
module pwbf_cfg
    import pwbf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_GAP:   cfg_next.frame_gap_ticks      = cfg_data[31:0];
                REG_HIGH_THRESH: cfg_next.high_threshold_ticks = cfg_data[31:0];
                REG_IDLE:        cfg_next.idle_pattern         = cfg_data[7:0];
                REG_ON_MODE:     cfg_next.toggle_mode[0]       = cfg_data[0];
                REG_IO_MODE:     cfg_next.toggle_mode[1]       = cfg_data[0];
                REG_PLUS_MODE:   cfg_next.toggle_mode[2]       = cfg_data[0];
                REG_MINUS_MODE:  cfg_next.toggle_mode[3]       = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_gap_ticks      <= FRAME_GAP_RESET;
            cfg_reg.high_threshold_ticks <= HIGH_THRESH_RESET;
            cfg_reg.idle_pattern         <= IDLE_RESET;
            cfg_reg.toggle_mode          <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/pwbf_core.sv
// Edge input register, decoder state and one-pass bit/byte/button decode.
// Depends on pwbf_pkg.
module pwbf_core
    import pwbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_BITS-1:0] edge_time,
    input  logic                 pin_level,
    input  logic                 out_free,
    output logic                 result_valid,
    output result_t              result
);

    logic                      in_valid_reg;
    logic [TIME_BITS-1:0]      edge_time_reg;
    logic                      pin_level_reg;

    logic [TIME_BITS-1:0]      prev_edge_reg;
    logic [TIME_BITS-1:0]      last_rise_reg;
    logic [COUNT_BITS-1:0]     bit_count_reg, bit_count_next;
    logic [BITS_PER_FRAME-1:0] shift_reg, shift_next;
    logic [BUTTON_COUNT-1:0]   prev_hits_reg, prev_hits_next;
    logic [BUTTON_COUNT-1:0]   toggle_reg, toggle_next;

    logic [TIME_BITS-1:0]      gap;
    logic [TIME_BITS-1:0]      high_time;
    logic                      gap_clear;
    logic                      bit_val;
    logic [COUNT_BITS-1:0]     base_count;
    logic [BITS_PER_FRAME-1:0] base_shift;
    logic [BITS_PER_FRAME-1:0] shifted;
    logic [BITS_PER_FRAME-1:0] delta;
    logic [BUTTON_COUNT-1:0]   hits;
    logic [BUTTON_COUNT-1:0]   buttons;
    logic                      last_bit;
    logic                      process;
    logic                      in_load;

    assign gap        = edge_time_reg - prev_edge_reg;
    assign high_time  = edge_time_reg - last_rise_reg;
    assign gap_clear  = gap > TIME_BITS'(cfg.frame_gap_ticks);
    assign bit_val    = high_time > TIME_BITS'(cfg.high_threshold_ticks);
    assign base_count = gap_clear ? '0 : bit_count_reg;
    assign base_shift = gap_clear ? '0 : shift_reg;
    assign shifted    = {base_shift[BITS_PER_FRAME-2:0], bit_val};
    assign last_bit   = !pin_level_reg && (base_count == COUNT_BITS'(BITS_PER_FRAME - 1));
    assign delta      = shifted ^ cfg.idle_pattern;

    assign process  = in_valid_reg && (!last_bit || out_free);
    assign in_stall = in_valid_reg && !process;
    assign in_load  = in_valid && !in_stall;

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            hits[i] = (delta & BUTTON_MASK[i]) == BUTTON_MASK[i];
        end
    end

    always_comb
    begin
        toggle_next = toggle_reg;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            if (cfg.toggle_mode[i])
            begin
                if (hits[i] && !prev_hits_reg[i])
                begin
                    toggle_next[i] = !toggle_reg[i];
                end
                buttons[i] = toggle_next[i];
            end
            else
            begin
                buttons[i] = hits[i];
            end
        end
    end

    always_comb
    begin
        bit_count_next = base_count;
        shift_next     = base_shift;
        prev_hits_next = prev_hits_reg;
        if (!pin_level_reg)
        begin
            if (last_bit)
            begin
                bit_count_next = '0;
                shift_next     = '0;
                prev_hits_next = hits;
            end
            else
            begin
                bit_count_next = base_count + 1'b1;
                shift_next     = shifted;
            end
        end
    end

    assign result_valid      = process && last_bit;
    assign result.frame_byte = shifted;
    assign result.buttons    = buttons;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            edge_time_reg <= edge_time;
            pin_level_reg <= pin_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg <= '0;
            last_rise_reg <= '0;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            prev_hits_reg <= '0;
            toggle_reg    <= '0;
        end
        else if (process)
        begin
            prev_edge_reg <= edge_time_reg;
            if (pin_level_reg)
            begin
                last_rise_reg <= edge_time_reg;
            end
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            prev_hits_reg <= prev_hits_next;
            if (last_bit)
            begin
                toggle_reg <= toggle_next;
            end
        end
    end

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_result_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!pin_level_reg && out_free))
        else $error("result without falling edge or free output");

    a_byte_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> (bit_count_reg == '0 && shift_reg == '0))
        else $error("bit counter not cleared after completed byte");

endmodule

### hdl/pwbf_out.sv
// Result register between the decode logic and the result channel.
// Depends on pwbf_pkg.
module pwbf_out
    import pwbf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_result
);

    logic    out_valid_reg;
    result_t result_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> !out_stall)
        else $error("pending result overwritten");

endmodule

### hdl/pulse_width_button_frame_decoder_unit.sv
// Top level of the pulse width button frame decoder.
// Depends on pwbf_pkg, pwbf_cfg, pwbf_core and pwbf_out.
//
// Each input beat is one pin edge (timestamp, level after the edge). One beat is
// taken per clock unless the input stalls; an edge sits in the input register,
// where the gap test, bit decode and button logic run in a single pass, and a
// completed byte is loaded into the result register. An edge that completes no
// byte never waits on the result side; an edge that completes a byte waits only
// while the result register holds a result that is stalled. Configuration writes
// are always ready and take effect on the next cycle; no reset sweep is needed.
module pulse_width_button_frame_decoder_unit
    import pwbf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [TIME_BITS-1:0]      edge_time,
    input  logic                      pin_level,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [BITS_PER_FRAME-1:0] frame_byte,
    output logic                      on_button,
    output logic                      io_button,
    output logic                      plus_button,
    output logic                      minus_button
);

    cfg_t    cfg;
    result_t result;
    result_t out_result;
    logic    result_valid;
    logic    out_free;

    pwbf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwbf_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .edge_time    (edge_time),
        .pin_level    (pin_level),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result       (result)
    );

    pwbf_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (result_valid),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign frame_byte   = out_result.frame_byte;
    assign on_button    = out_result.buttons[0];
    assign io_button    = out_result.buttons[1];
    assign plus_button  = out_result.buttons[2];
    assign minus_button = out_result.buttons[3];

endmodule

### bench/pulse_width_button_frame_decoder_unit_test.sv
// Self-checking bench for pulse_width_button_frame_decoder_unit: edge beats with
// random gaps and stalls, checked against an in-bench decoder of frames and buttons.
// Depends on pwbf_pkg and the decoder RTL.
`timescale 1ns / 100ps

module pulse_width_button_frame_decoder_unit_test;
    import pwbf_pkg::*;

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_EDGES   = 128;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;
    // on, io, plus, minus
    localparam logic [7:0] KEY_MASKS [4] = '{8'h48, 8'h12, 8'h24, 8'h01};

    typedef struct {
        logic [31:0] stamp;
        logic        level;
        logic        drain;
    } pin_edge_t;

    typedef struct {
        logic [7:0] raw;
        logic       on_state;
        logic       io_state;
        logic       plus_state;
        logic       minus_state;
    } frame_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [TIME_BITS-1:0]      edge_time = '0;
    logic                      pin_level = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [BITS_PER_FRAME-1:0] frame_byte;
    logic                      on_button;
    logic                      io_button;
    logic                      plus_button;
    logic                      minus_button;

    // register mirror
    logic [31:0] gap_limit = 32'd10000;
    logic [31:0] high_limit = 32'd1000;
    logic [7:0]  idle_byte = 8'hFF;
    logic [3:0]  toggle_mode = 4'h0;

    // decoder state
    logic [31:0] prev_stamp = '0;
    logic [31:0] rise_stamp = '0;
    logic [2:0]  bit_pos = '0;
    logic [7:0]  shift_reg = '0;
    logic [3:0]  last_hits = '0;
    logic [3:0]  toggled = '0;

    pin_edge_t   edge_queue[$];
    frame_t      frames_due[$];
    pin_edge_t   next_edge;
    frame_t      want;
    logic [31:0] stamp_now = '0;
    logic        hold_next = 1'b0;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          items_made = 0;
    int          edges_taken = 0;
    int          frames_seen = 0;
    int          errors = 0;

    pulse_width_button_frame_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .edge_time    (edge_time),
        .pin_level    (pin_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .on_button    (on_button),
        .io_button    (io_button),
        .plus_button  (plus_button),
        .minus_button (minus_button)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic decode_edge(input logic [31:0] stamp, input logic level);
        logic [31:0] gap;
        logic [31:0] high_len;
        logic [7:0]  delta;
        logic [3:0]  hits;
        logic [3:0]  shown;
        frame_t      f;
        gap = stamp - prev_stamp;
        prev_stamp = stamp;
        if (gap > gap_limit)
        begin
            bit_pos = '0;
            shift_reg = '0;
        end
        if (level)
            rise_stamp = stamp;
        else
        begin
            high_len = stamp - rise_stamp;
            shift_reg = {shift_reg[6:0], high_len > high_limit};
            if (bit_pos != 3'd7)
                bit_pos = bit_pos + 3'd1;
            else
            begin
                delta = shift_reg ^ idle_byte;
                for (int b = 0; b < 4; b++)
                begin
                    hits[b] = (delta & KEY_MASKS[b]) == KEY_MASKS[b];
                    if (toggle_mode[b] && hits[b] && !last_hits[b])
                        toggled[b] = ~toggled[b];
                    shown[b] = toggle_mode[b] ? toggled[b] : hits[b];
                end
                f.raw = shift_reg;
                f.on_state = shown[0];
                f.io_state = shown[1];
                f.plus_state = shown[2];
                f.minus_state = shown[3];
                frames_due.push_back(f);
                last_hits = hits;
                bit_pos = '0;
                shift_reg = '0;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
        end
    endtask

    // edge driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            edge_time <= '0;
            pin_level <= 1'b0;
            send_idle <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_edge(edge_time, pin_level);
                edges_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_idle != 0)
                begin
                    in_valid <= 1'b0;
                    send_idle <= send_idle - 1;
                end
                else if (edge_queue.size() != 0 &&
                         !(edge_queue[0].drain && frames_due.size() != 0))
                begin
                    next_edge = edge_queue.pop_front();
                    in_valid <= 1'b1;
                    edge_time <= next_edge.stamp;
                    pin_level <= next_edge.level;
                    send_idle <= send_burst ? 0 : $urandom_range(18, 0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and register mirror
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_idle <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_GAP:   gap_limit = cfg_data;
                    REG_HIGH_THRESH: high_limit = cfg_data;
                    REG_IDLE:        idle_byte = cfg_data[7:0];
                    REG_ON_MODE:     toggle_mode[0] = cfg_data[0];
                    REG_IO_MODE:     toggle_mode[1] = cfg_data[0];
                    REG_PLUS_MODE:   toggle_mode[2] = cfg_data[0];
                    REG_MINUS_MODE:  toggle_mode[3] = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                frames_seen++;
                if (frames_due.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected beat, expected none, actual frame_byte %h",
                             $time, frame_byte);
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("frame_byte", want.raw, frame_byte);
                    check_field("on_button", 8'(want.on_state), 8'(on_button));
                    check_field("io_button", 8'(want.io_state), 8'(io_button));
                    check_field("plus_button", 8'(want.plus_state), 8'(plus_button));
                    check_field("minus_button", 8'(want.minus_state), 8'(minus_button));
                end
            end
            if (recv_idle != 0)
            begin
                out_stall <= 1'b1;
                recv_idle <= recv_idle - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    recv_idle <= recv_burst ? 0 : $urandom_range(18, 0);
            end
        end
    end

    task automatic push_edge(input logic [31:0] stamp, input logic level);
        pin_edge_t e;
        e.stamp = stamp;
        e.level = level;
        e.drain = hold_next;
        hold_next = 1'b0;
        edge_queue.push_back(e);
        stamp_now = stamp;
        items_made++;
    endtask

    task automatic emit_bit(input logic [31:0] low_len, input logic [31:0] high_len);
        push_edge(stamp_now + low_len, 1'b1);
        push_edge(stamp_now + high_len, 1'b0);
    endtask

    function automatic logic [31:0] pulse_len(input logic one);
        logic [31:0] lo;
        logic [31:0] hi;
        if (one)
        begin
            lo = high_limit + 32'd1;
            hi = (gap_limit > high_limit) ? gap_limit : lo;
        end
        else
        begin
            lo = '0;
            hi = (gap_limit < high_limit) ? gap_limit : high_limit;
        end
        case ($urandom_range(3, 0))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic logic [31:0] low_gap();
        case ($urandom_range(3, 0))
            0: return gap_limit;
            1: return '0;
            default: return $urandom_range(gap_limit, 0);
        endcase
    endfunction

    function automatic logic [7:0] frame_value();
        logic [7:0] combo;
        combo = '0;
        for (int b = 0; b < 4; b++)
            if ($urandom_range(1, 0))
                combo = combo | KEY_MASKS[b];
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4: return idle_byte ^ combo;
            5, 6:          return idle_byte ^ (combo | 8'($urandom));
            7:             return idle_byte;
            default:       return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic [7:0] value, input int edge_cap);
        logic [31:0] lead;
        int          left;
        left = edge_cap;
        if (gap_limit != 32'hFFFF_FFFF)
            lead = (gap_limit > 32'hFFFF_0000) ? gap_limit + 32'd1 :
                   gap_limit + 32'd1 + $urandom_range(1000, 0);
        else
            lead = $urandom_range(5000, 0);
        for (int i = 7; i >= 0; i--)
        begin
            if (left > 0)
                push_edge(stamp_now + ((i == 7) ? lead : low_gap()), 1'b1);
            left--;
            if (left > 0)
                push_edge(stamp_now + pulse_len(value[i]), 1'b0);
            left--;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] gap, input logic [31:0] thr,
                              input logic [7:0] idle, input logic [3:0] modes);
        write_reg(REG_FRAME_GAP, gap);
        write_reg(REG_HIGH_THRESH, thr);
        write_reg(REG_IDLE, {24'($urandom), idle});
        write_reg(REG_ON_MODE, {31'($urandom), modes[0]});
        write_reg(REG_IO_MODE, {31'($urandom), modes[1]});
        write_reg(REG_PLUS_MODE, {31'($urandom), modes[2]});
        write_reg(REG_MINUS_MODE, {31'($urandom), modes[3]});
        write_reg(CFG_SPARE, $urandom);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (edge_queue.size() != 0 || in_valid || frames_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] gap;
        logic [31:0] thr;
        logic [7:0]  idle;
        int          phase_start;
        int          pick;
        logic        drained;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fall with no rise, repeated falls and rises, then a wrapping byte
        push_edge(32'd0, 1'b0);
        push_edge(32'd2000, 1'b0);
        push_edge(32'd2500, 1'b1);
        push_edge(32'd2600, 1'b1);
        push_edge(32'd3100, 1'b0);
        stamp_now = 32'hFFFF_FFFF;
        emit_bit(32'd0, 32'd1500);
        emit_bit(32'd300, 32'd1000);
        emit_bit(32'd10000, 32'd999);
        emit_bit(32'd1, 32'd0);
        emit_bit(32'd500, 32'd1000);
        emit_bit(32'd500, 32'd1);
        emit_bit(32'd9999, 32'd2);
        emit_bit(32'd200, 32'd1001);
        wait_idle();

        for (int phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            case (phase)
                1: set_config(32'hFFFF_FFFF, 32'd0, 8'h00, 4'hF);
                2: set_config(32'd0, 32'hFFFF_FFFF, 8'hFF, 4'h0);
                3: set_config(32'hFFFF_FFFF, $urandom_range(5000, 0), 8'($urandom), 4'hA);
                default:
                begin
                    gap = $urandom_range(20000, 50);
                    thr = ($urandom_range(4, 0) == 0) ? $urandom_range(30000, gap) :
                          $urandom_range(gap - 1, 0);
                    case ($urandom_range(3, 0))
                        0: idle = 8'hFF;
                        1: idle = 8'h00;
                        default: idle = 8'($urandom);
                    endcase
                    set_config(gap, thr, idle, 4'($urandom));
                end
            endcase
            @(negedge clk);
            send_burst = ($urandom_range(3, 0) == 0);
            recv_burst = ($urandom_range(3, 0) == 0);
            phase_start = items_made;
            drained = 1'b0;
            while (items_made - phase_start < PHASE_EDGES)
            begin
                if (!drained && items_made - phase_start >= PHASE_EDGES / 2)
                begin
                    hold_next = 1'b1;
                    drained = 1'b1;
                end
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    send_frame(frame_value(), 16);
                else if (pick < 80)
                    send_frame(frame_value(), $urandom_range(15, 1));
                else if (pick < 92)
                    repeat ($urandom_range(6, 1))
                        push_edge(stamp_now + low_gap(), 1'($urandom_range(1, 0)));
                else
                    push_edge($urandom, 1'($urandom_range(1, 0)));
            end
            wait_idle();
        end

        repeat (6) @(posedge clk);
        $display("covered %0d edge beats and %0d frame beats over %0d register settings",
                 edges_taken, frames_seen, RANDOM_PHASES + 1);
        if (errors == 0)
            $display("pulse_width_button_frame_decoder_unit regression: pass");
        else
            $display("pulse_width_button_frame_decoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("pulse_width_button_frame_decoder_unit regression: fail");
        $finish;
    end

endmodule
